### rtl/core/learning_table_with_aging_top_assert.svh
// assertion macros for the learning table checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef LEARNING_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define LEARNING_TABLE_WITH_AGING_TOP_ASSERT_SVH

// same-cycle implication
`define LTWA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("learning table assertion failed");

// next-cycle implication
`define LTWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("learning table assertion failed");

`endif

### rtl/core/ltwa_pkg.sv
// shared types and constants of the learning table with aging
// no dependencies
package ltwa_pkg;

  localparam int unsigned LIST_CNT_W = 5;
  localparam logic [LIST_CNT_W-1:0] MAX_RESULTS = 5'd16;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TTL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC = 2'd1;

  localparam logic [31:0] DEFAULT_TTL_RST = 32'd300;
  localparam logic [31:0] EXPECTED_MAGIC_RST = 32'h5A44_5001;

  typedef enum logic [2:0] {
    OP_ANNOUNCE = 3'd0,
    OP_LEAVE    = 3'd1,
    OP_QUERY    = 3'd2,
    OP_SWEEP    = 3'd3,
    OP_LIST     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } st_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] magic;
    logic        payload_complete;
    logic [63:0] entry_key;
    logic [31:0] entry_ttl;
    logic [31:0] entry_info;
    logic [31:0] now_sec;
    logic [4:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_entry;
    logic [63:0] out_key;
    logic [31:0] out_ttl;
    logic [31:0] out_info;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] ttl;
    logic [31:0] info;
    logic [31:0] seen;
  } slot_t;

  typedef struct packed {
    logic load_item;
    logic idx_step;
    logic slot_write;
    logic slot_alloc;
    logic act_clr;
    logic pend_take;
    logic push;
    st_e  push_status;
    logic push_entry;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       magic_ok;
    logic       complete;
    logic       walk_done;
    logic       key_hit;
    logic       slot_act;
    logic       expired;
    logic       used_full;
    logic       can_push;
    logic       pend_valid;
    logic       cap_zero;
    logic       cap_hit_next;
  } sts_t;

endpackage

### rtl/core/ltwa_ram.sv
// generic single write port ram with registered read
// no dependencies
module ltwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ltwa_datapath.sv
// datapath: item and config registers, slot ram, active bits, walk index,
// list pending entry and output register; uses ltwa_pkg and ltwa_ram
module ltwa_datapath #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ltwa_pkg::in_item_t                  in_data_i,
  input  logic                                cfg_we_i,
  input  logic [ltwa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  ltwa_pkg::cmd_t                      cmd_i,
  output ltwa_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output ltwa_pkg::out_item_t                 out_data_o
);

  localparam int unsigned IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned SLOT_W = $bits(ltwa_pkg::slot_t);

  ltwa_pkg::in_item_t  item_q;
  logic [31:0]         default_ttl_q, magic_q;
  logic [CNT_W-1:0]    used_q, idx_q;
  logic [TABLE_SLOTS-1:0] act_q, act_d;
  logic                pend_valid_q;
  ltwa_pkg::slot_t     pend_q;
  logic [ltwa_pkg::LIST_CNT_W-1:0] cnt_q, cap;
  logic                out_valid_q;
  ltwa_pkg::out_item_t out_q;

  logic [IDX_W-1:0]    waddr;
  ltwa_pkg::slot_t     wslot, rslot;
  logic [SLOT_W-1:0]   rdata;
  logic [31:0]         lim, age;

  assign waddr = cmd_i.slot_alloc ? used_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign wslot = '{key: item_q.entry_key, ttl: item_q.entry_ttl,
                   info: item_q.entry_info, seen: item_q.now_sec};

  ltwa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.slot_write),
    .waddr_i(waddr),
    .wdata_i(wslot),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign rslot = rdata;

  // aging: wrapping age against own ttl or the default
  assign lim = (rslot.ttl != 32'd0) ? rslot.ttl : default_ttl_q;
  assign age = item_q.now_sec - rslot.seen;

  assign cap = (item_q.max_count > ltwa_pkg::MAX_RESULTS) ? ltwa_pkg::MAX_RESULTS
                                                          : item_q.max_count;

  always_comb begin
    act_d = act_q;
    if (cmd_i.slot_write) begin
      act_d[waddr] = 1'b1;
    end
    if (cmd_i.act_clr) begin
      act_d[idx_q[IDX_W-1:0]] = 1'b0;
    end
  end

  always_comb begin
    sts_o.op           = item_q.opcode;
    sts_o.magic_ok     = (item_q.magic == magic_q);
    sts_o.complete     = item_q.payload_complete;
    sts_o.walk_done    = (idx_q >= used_q);
    sts_o.key_hit      = (rslot.key == item_q.entry_key);
    sts_o.slot_act     = act_q[idx_q[IDX_W-1:0]];
    sts_o.expired      = (age > lim);
    sts_o.used_full    = (used_q == CNT_W'(TABLE_SLOTS));
    sts_o.can_push     = !out_valid_q || out_ready_i;
    sts_o.pend_valid   = pend_valid_q;
    sts_o.cap_zero     = (cap == '0);
    sts_o.cap_hit_next = ((cnt_q + ltwa_pkg::LIST_CNT_W'(1)) == cap);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_ttl_q <= ltwa_pkg::DEFAULT_TTL_RST;
      magic_q       <= ltwa_pkg::EXPECTED_MAGIC_RST;
      used_q        <= '0;
      idx_q         <= '0;
      act_q         <= '0;
      pend_valid_q  <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == ltwa_pkg::CFG_DEFAULT_TTL)) begin
        default_ttl_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == ltwa_pkg::CFG_EXPECTED_MAGIC)) begin
        magic_q <= cfg_data_i;
      end
      act_q <= act_d;
      if (cmd_i.slot_write && cmd_i.slot_alloc) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.load_item) begin
        idx_q        <= '0;
        cnt_q        <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        if (cmd_i.idx_step) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (cmd_i.pend_take) begin
          cnt_q        <= cnt_q + ltwa_pkg::LIST_CNT_W'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.pend_take) begin
      pend_q <= rslot;
    end
    if (cmd_i.push) begin
      out_q.status    <= cmd_i.push_status;
      out_q.has_entry <= cmd_i.push_entry;
      out_q.out_key   <= cmd_i.push_entry ? pend_q.key  : 64'd0;
      out_q.out_ttl   <= cmd_i.push_entry ? pend_q.ttl  : 32'd0;
      out_q.out_info  <= cmd_i.push_entry ? pend_q.info : 32'd0;
      out_q.last      <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/ltwa_ctrl.sv
// controller state machine: decodes an item, walks the slots, issues results
// uses ltwa_pkg command and status structs
module ltwa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           idle_o,
  input  ltwa_pkg::sts_t sts_i,
  output ltwa_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT,
    S_CHK,
    S_END,
    S_RESP,
    S_LEND
  } state_e;

  state_e        state_q, state_d;
  ltwa_pkg::st_e res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.push_status = ltwa_pkg::ST_APPLIED;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((sts_i.op == ltwa_pkg::OP_ANNOUNCE || sts_i.op == ltwa_pkg::OP_LEAVE ||
             sts_i.op == ltwa_pkg::OP_QUERY) && !sts_i.magic_ok) begin
          res_d   = ltwa_pkg::ST_IGNORED;
          state_d = S_RESP;
        end else begin
          unique case (sts_i.op)
            ltwa_pkg::OP_ANNOUNCE: begin
              if (sts_i.complete) begin
                state_d = S_WAIT;
              end else begin
                res_d   = ltwa_pkg::ST_IGNORED;
                state_d = S_RESP;
              end
            end
            ltwa_pkg::OP_LEAVE, ltwa_pkg::OP_SWEEP: state_d = S_WAIT;
            ltwa_pkg::OP_LIST: state_d = sts_i.cap_zero ? S_LEND : S_WAIT;
            default: begin
              res_d   = ltwa_pkg::ST_IGNORED;
              state_d = S_RESP;
            end
          endcase
        end
      end
      // slot data for the current index lands in the read register
      S_WAIT: begin
        state_d = sts_i.walk_done ? S_END : S_CHK;
      end
      S_CHK: begin
        unique case (sts_i.op)
          ltwa_pkg::OP_ANNOUNCE: begin
            if (sts_i.key_hit) begin
              cmd_o.slot_write = 1'b1;
              res_d   = ltwa_pkg::ST_APPLIED;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_step = 1'b1;
              state_d = S_WAIT;
            end
          end
          ltwa_pkg::OP_LEAVE: begin
            if (sts_i.key_hit) begin
              cmd_o.act_clr = 1'b1;
              res_d   = ltwa_pkg::ST_APPLIED;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_step = 1'b1;
              state_d = S_WAIT;
            end
          end
          ltwa_pkg::OP_SWEEP: begin
            cmd_o.act_clr  = sts_i.slot_act && sts_i.expired;
            cmd_o.idx_step = 1'b1;
            state_d = S_WAIT;
          end
          ltwa_pkg::OP_LIST: begin
            if (!sts_i.slot_act) begin
              cmd_o.idx_step = 1'b1;
              state_d = S_WAIT;
            end else if (!sts_i.pend_valid || sts_i.can_push) begin
              // older pending entry goes out, this one waits for the last flag
              cmd_o.push       = sts_i.pend_valid;
              cmd_o.push_entry = 1'b1;
              cmd_o.pend_take  = 1'b1;
              if (sts_i.cap_hit_next) begin
                state_d = S_LEND;
              end else begin
                cmd_o.idx_step = 1'b1;
                state_d = S_WAIT;
              end
            end
          end
          default: begin
            res_d   = ltwa_pkg::ST_IGNORED;
            state_d = S_RESP;
          end
        endcase
      end
      S_END: begin
        state_d = S_RESP;
        unique case (sts_i.op)
          ltwa_pkg::OP_ANNOUNCE: begin
            if (sts_i.used_full) begin
              res_d = ltwa_pkg::ST_FULL;
            end else begin
              cmd_o.slot_write = 1'b1;
              cmd_o.slot_alloc = 1'b1;
              res_d = ltwa_pkg::ST_APPLIED;
            end
          end
          ltwa_pkg::OP_LEAVE: res_d = ltwa_pkg::ST_NOT_FOUND;
          ltwa_pkg::OP_LIST:  state_d = S_LEND;
          default:            res_d = ltwa_pkg::ST_APPLIED;
        endcase
      end
      S_RESP: begin
        if (sts_i.can_push) begin
          cmd_o.push        = 1'b1;
          cmd_o.push_status = res_q;
          cmd_o.push_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LEND: begin
        if (sts_i.can_push) begin
          cmd_o.push       = 1'b1;
          cmd_o.push_entry = sts_i.pend_valid;
          cmd_o.push_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ltwa_pkg::ST_APPLIED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

### rtl/core/learning_table_with_aging_top.sv
// learning table with aging: one item at a time; wrong magic, query and bad ops are
// answered without a walk; announce, leave and sweep walk used slots (one ram read and
// one check per slot); list walks the same way and stalls on output
// a result register parts the output side, so the next item is taken while it waits
// reset clears active bits and fill count and loads the config reset values at once,
// with no clearing pass; slot contents are left as they were
module learning_table_with_aging_top #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input item channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ltwa_pkg::in_item_t             in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ltwa_pkg::out_item_t            out_data_o,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [ltwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  ltwa_pkg::cmd_t cmd;
  ltwa_pkg::sts_t sts;
  logic           idle;

  // controller: sequences decode, slot walk and result beats
  ltwa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .idle_o    (idle),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: slot ram, active bits, compares, output register
  ltwa_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // a new item is taken whenever the controller is between items
  assign in_ready_o = idle;

endmodule

### rtl/core/ltwa_checker.sv
// port level checks of the learning table, bound to the top level
// uses ltwa_pkg and learning_table_with_aging_top_assert.svh
`include "learning_table_with_aging_top_assert.svh"

module ltwa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input ltwa_pkg::out_item_t            out_data_i
);

  logic out_beat;
  logic out_stall;
  logic entry_beat;
  logic empty_beat;
  logic empty_clean;

  assign out_beat    = out_valid_i && out_ready_i;
  assign out_stall   = out_valid_i && !out_ready_i;
  assign entry_beat  = out_beat && out_data_i.has_entry;
  assign empty_beat  = out_beat && !out_data_i.has_entry;
  assign empty_clean = out_data_i.last && (out_data_i.out_key == 64'd0) &&
                       (out_data_i.out_ttl == 32'd0) && (out_data_i.out_info == 32'd0);

  // a stalled result beat holds
  `LTWA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_data_i))
  // the block goes busy right after taking an item
  `LTWA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  // listed entries only come with an applied status
  `LTWA_ASSERT_NOW(a_entry_status, entry_beat, out_data_i.status == ltwa_pkg::ST_APPLIED)
  // a beat without an entry is final and carries zero fields
  `LTWA_ASSERT_NOW(a_empty_beat, empty_beat, empty_clean)

endmodule

bind learning_table_with_aging_top ltwa_checker u_ltwa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

### tb/sv/tb_learning_table_with_aging_top.sv
// self-checking testbench for learning_table_with_aging_top: directed and random peer-table traffic
// keeps its own copy of the table and checks every result beat in order
// depends on ltwa_pkg and the learning_table_with_aging_top rtl
module tb_learning_table_with_aging_top;
  import ltwa_pkg::*;

  localparam int SLOTS       = 16;
  localparam int KEY_POOL    = 20;      // more keys than slots, so the table fills up
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int TIMEOUT     = 4000000;

  // opcodes and register indexes that the package leaves unnamed
  localparam logic [2:0] OP_RSVD5  = 3'd5;
  localparam logic [2:0] OP_RSVD6  = 3'd6;
  localparam logic [2:0] OP_RSVD7  = 3'd7;
  localparam logic [1:0] CFG_RSVD2 = 2'd2;
  localparam logic [1:0] CFG_RSVD3 = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  learning_table_with_aging_top #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the peer table and its registers
  logic [63:0] tbl_key  [SLOTS];
  logic [31:0] tbl_ttl  [SLOTS];
  logic [31:0] tbl_info [SLOTS];
  logic [31:0] tbl_seen [SLOTS];
  logic        tbl_live [SLOTS];
  int          tbl_used;
  logic [31:0] cfg_dflt_ttl;
  logic [31:0] cfg_magic;

  // result beats still owed by the block, oldest first
  out_item_t   due_results[$];

  logic [63:0] key_pool [KEY_POOL];
  logic [31:0] clock_sec;

  // handshake shaping
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  bit          offering;

  // bookkeeping
  int          fail_count;
  int          items_offered;
  int          items_taken;
  int          beats_seen;
  int          full_count;
  int          aged_count;
  int          listed_count;

  function automatic int find_slot(logic [63:0] key);
    int i;
    for (i = 0; i < tbl_used; i++)
      if (tbl_key[i] == key) return i;
    return -1;
  endfunction

  // work out the result beats of one accepted item and update the shadow table
  function automatic void apply_to_table(in_item_t it);
    out_item_t   res;
    int          slot;
    int          cap;
    int          total;
    int          emitted;
    int          i;
    logic [31:0] limit_s;
    res = '0;
    res.status = ST_APPLIED;
    res.last = 1'b1;
    // magic only guards announce, leave and query
    if (it.opcode <= OP_QUERY && it.magic != cfg_magic) begin
      res.status = ST_IGNORED;
    end else begin
      case (it.opcode)
        OP_ANNOUNCE: begin
          if (!it.payload_complete) begin
            res.status = ST_IGNORED;
          end else begin
            // reuse the first matching slot, active or not, else append
            slot = find_slot(it.entry_key);
            if (slot < 0 && tbl_used < SLOTS) begin
              slot = tbl_used;
              tbl_used++;
            end
            if (slot < 0) begin
              res.status = ST_FULL;
              full_count++;
            end else begin
              tbl_key[slot]  = it.entry_key;
              tbl_ttl[slot]  = it.entry_ttl;
              tbl_info[slot] = it.entry_info;
              tbl_seen[slot] = it.now_sec;
              tbl_live[slot] = 1'b1;
            end
          end
        end
        OP_LEAVE: begin
          slot = find_slot(it.entry_key);
          if (slot < 0) res.status = ST_NOT_FOUND;
          else tbl_live[slot] = 1'b0;
        end
        OP_SWEEP: begin
          for (i = 0; i < tbl_used; i++) begin
            limit_s = (tbl_ttl[i] != 0) ? tbl_ttl[i] : cfg_dflt_ttl;
            // age wraps modulo 2^32
            if (tbl_live[i] && (it.now_sec - tbl_seen[i]) > limit_s) begin
              tbl_live[i] = 1'b0;
              aged_count++;
            end
          end
        end
        OP_LIST: begin
          cap = int'((it.max_count > MAX_RESULTS) ? MAX_RESULTS : it.max_count);
          total = 0;
          for (i = 0; i < tbl_used; i++)
            if (tbl_live[i] && total < cap) total++;
          if (total != 0) begin
            emitted = 0;
            for (i = 0; i < tbl_used && emitted < total; i++) begin
              if (tbl_live[i]) begin
                emitted++;
                res.has_entry = 1'b1;
                res.out_key   = tbl_key[i];
                res.out_ttl   = tbl_ttl[i];
                res.out_info  = tbl_info[i];
                res.last      = (emitted == total);
                due_results.push_back(res);
              end
            end
            listed_count += total;
            return;
          end
        end
        default: res.status = ST_IGNORED;
      endcase
    end
    due_results.push_back(res);
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // compare every result beat with the oldest expectation, then predict new input beats
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %p", $time, out_data_o);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_data_o.status));
          check_field("has_entry", 64'(want.has_entry), 64'(out_data_o.has_entry));
          check_field("out_key", want.out_key, out_data_o.out_key);
          check_field("out_ttl", 64'(want.out_ttl), 64'(out_data_o.out_ttl));
          check_field("out_info", 64'(want.out_info), 64'(out_data_o.out_info));
          check_field("last", 64'(want.last), 64'(out_data_o.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_to_table(in_data_i);
        items_taken++;
      end
    end
  end

  // result sink: random stalls, plus a long hold-off counted down here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // offer one beat; valid stays up into the next item unless an idle gap is drawn
  task automatic send_item(input in_item_t item);
    if (!offering) begin
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_offered++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // block is idle once every accepted item is predicted and all its beats are back
  task automatic wait_drained();
    stop_sending();
    while (items_taken != items_offered || due_results.size() != 0) @(posedge clk_i);
  endtask

  // write both registers, then poke the unused indexes, which must change nothing
  task automatic set_config(input logic [31:0] ttl_val, input logic [31:0] magic_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEFAULT_TTL;
    cfg_data_i  <= ttl_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_EXPECTED_MAGIC;
    cfg_data_i  <= magic_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_RSVD2;
    cfg_data_i  <= $urandom;
    @(posedge clk_i);
    cfg_index_i <= CFG_RSVD3;
    cfg_data_i  <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_dflt_ttl = ttl_val;
    cfg_magic    = magic_val;
  endtask

  function automatic in_item_t make_item(logic [2:0] op, logic [63:0] key, logic [31:0] ttl,
                                         logic [31:0] info, logic [31:0] now_s,
                                         logic [4:0] cnt);
    in_item_t it;
    it.opcode           = op;
    it.magic            = cfg_magic;
    it.payload_complete = 1'b1;
    it.entry_key        = key;
    it.entry_ttl        = ttl;
    it.entry_info       = info;
    it.now_sec          = now_s;
    it.max_count        = cnt;
    return it;
  endfunction

  function automatic logic [31:0] pick_ttl();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 32'd0;   // falls back to the default
    if (r < 8) return $urandom_range(1, 60);
    return $urandom;
  endfunction

  // mostly well-formed traffic on a slowly moving clock, with some noise
  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    if ($urandom_range(0, 49) == 0) clock_sec = $urandom;
    else clock_sec = clock_sec + $urandom_range(0, 25);
    it = make_item(OP_ANNOUNCE, key_pool[$urandom_range(0, KEY_POOL - 1)], pick_ttl(),
                   $urandom, clock_sec,
                   5'(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 16)));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      it.opcode = OP_ANNOUNCE;
    end else if (pick < 52) begin
      it.opcode = OP_LEAVE;
      if ($urandom_range(0, 3) == 0) it.entry_key = {$urandom, $urandom};
    end else if (pick < 66) begin
      it.opcode = OP_SWEEP;
    end else if (pick < 84) begin
      it.opcode = OP_LIST;
    end else if (pick < 88) begin
      it.opcode = OP_QUERY;
    end else if (pick < 91) begin
      it.opcode = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    end else if (pick < 95) begin
      it.opcode = OP_ANNOUNCE;
      it.payload_complete = 1'b0;
    end else begin
      // broken header on a guarded opcode
      it.opcode = 3'($urandom_range(OP_ANNOUNCE, OP_QUERY));
      it.magic = $urandom;
      if (it.magic == cfg_magic) it.magic[0] = ~it.magic[0];
    end
    // sweep and list ignore the header and the completion flag
    if (it.opcode >= OP_SWEEP) begin
      if ($urandom_range(0, 1) == 1) it.magic = $urandom;
      it.payload_complete = 1'($urandom_range(0, 1));
    end else if (it.opcode != OP_ANNOUNCE) begin
      it.payload_complete = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- directed tests

  // list, sweep and leave on a table with nothing in it
  task automatic test_empty_table();
    send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, 32'd0, MAX_RESULTS));
    send_item(make_item(OP_SWEEP, 64'd0, 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_LEAVE, key_pool[0], 32'd0, 32'd0, 32'd0, 5'd0));
  endtask

  // wrong magic, query, unused opcodes and a short announce record are all ignored
  task automatic test_header_checks();
    in_item_t it;
    it = make_item(OP_ANNOUNCE, key_pool[0], 32'd1, 32'd1, 32'd1, 5'd0);
    it.magic = cfg_magic ^ 32'd1;
    send_item(it);
    it.opcode = OP_LEAVE;
    send_item(it);
    it.opcode = OP_QUERY;
    it.magic = ~cfg_magic;
    send_item(it);
    send_item(make_item(OP_QUERY, key_pool[0], 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_RSVD5, key_pool[0], 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_RSVD6, key_pool[0], 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_RSVD7, key_pool[1], '1, '1, '1, '1));
    it = make_item(OP_ANNOUNCE, key_pool[0], 32'd9, 32'd9, 32'd9, 5'd0);
    it.payload_complete = 1'b0;
    send_item(it);
  endtask

  // field extremes, re-announce of a known key, leave on an already inactive slot
  task automatic test_announce_leave();
    send_item(make_item(OP_ANNOUNCE, key_pool[0], 32'd0, 32'd0, 32'hFFFF_FFF0, 5'd0));
    send_item(make_item(OP_ANNOUNCE, key_pool[1], '1, '1, '1, 5'd0));
    send_item(make_item(OP_ANNOUNCE, key_pool[0], 32'd5, $urandom, 32'hFFFF_FFF8, 5'd0));
    send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, 32'd0, 5'd1));
    send_item(make_item(OP_LEAVE, key_pool[1], 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_LEAVE, key_pool[1], 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, 32'd0, 5'd31));
  endtask

  // expiry across the 2^32 wrap and at the exact default-ttl boundary
  task automatic test_sweep_aging();
    send_item(make_item(OP_ANNOUNCE, key_pool[2], 32'd0, $urandom, 32'hFFFF_FFF8, 5'd0));
    send_item(make_item(OP_SWEEP, 64'd0, 32'd0, 32'd0, 32'd3, 5'd0));
    send_item(make_item(OP_SWEEP, 64'd0, 32'd0, 32'd0, 32'h0000_0124, 5'd0));
    send_item(make_item(OP_SWEEP, 64'd0, 32'd0, 32'd0, 32'h0000_0125, 5'd0));
    send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, 32'd0, 5'd0));
    send_item(make_item(OP_ANNOUNCE, key_pool[3], 32'd7, $urandom, 32'h0000_0125, 5'd0));
    send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, 32'd0, MAX_RESULTS));
  endtask

  // ---------------------------------------------------------------- random tests

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < n; i++) send_item(rand_item());
    wait_drained();
  endtask

  // announce every pool key, the keys past the last slot come back as table full
  task automatic test_fill_table();
    int i;
    for (i = 0; i < KEY_POOL; i++) begin
      clock_sec = clock_sec + $urandom_range(0, 3);
      send_item(make_item(OP_ANNOUNCE, key_pool[i], pick_ttl(), $urandom, clock_sec, 5'd0));
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_output_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 4; i++)
      send_item(make_item(OP_ANNOUNCE, key_pool[i], 32'd0, $urandom, clock_sec, 5'd0));
    for (i = 0; i < 16; i++)
      send_item(make_item(OP_LIST, 64'd0, 32'd0, 32'd0, clock_sec, MAX_RESULTS));
    wait_drained();
  endtask

  // ---------------------------------------------------------------- run control

  initial begin
    int i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_DEFAULT_TTL;
    cfg_data_i  = '0;
    offering    = 1'b0;
    hold_left   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tbl_used     = 0;
    cfg_dflt_ttl = DEFAULT_TTL_RST;
    cfg_magic    = EXPECTED_MAGIC_RST;
    for (i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
    // key pool holds both extremes plus random keys
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    clock_sec = 32'hFFFF_FF00;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part runs on the reset values of both registers
    test_empty_table();
    test_header_checks();
    test_announce_leave();
    test_sweep_aging();
    wait_drained();

    // random part, with a new register setting before each random or backpressure phase
    set_config(32'd20, $urandom);
    test_random_traffic(50, 0, 0);
    test_fill_table();
    set_config(32'd1, 32'hFFFF_FFFF);
    test_random_traffic(50, 67, 0);
    set_config(32'd0, 32'd0);
    test_random_traffic(50, 0, 67);
    set_config(32'hFFFF_FFFF, EXPECTED_MAGIC_RST);
    test_output_backpressure();
    set_config(DEFAULT_TTL_RST, EXPECTED_MAGIC_RST);
    test_random_traffic(60, 9, 9);

    // give a stray late beat the chance to show up
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d items and %0d result beats: %0d full-table announces,",
             items_taken, beats_seen, full_count);
    $display("%0d entries aged out and %0d entries listed over five register settings",
             aged_count, listed_count);
    if (fail_count == 0) begin
      $display("learning_table_with_aging_top regression: pass");
    end else begin
      $display("learning_table_with_aging_top regression: fail");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT);
    $display("timeout with %0d result beats still owed", due_results.size());
    $display("learning_table_with_aging_top regression: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ltwa_pkg.sv
rtl/core/ltwa_ram.sv
rtl/core/ltwa_datapath.sv
rtl/core/ltwa_ctrl.sv
rtl/core/learning_table_with_aging_top.sv
rtl/core/ltwa_checker.sv
tb/sv/tb_learning_table_with_aging_top.sv
